[hdl/upc_pkg.sv]
// Package for the unique permutation collector.
// Holds sizes, result status codes, register indexes and the cell control word.
// No dependencies.
package upc_pkg;

  localparam int MAX_LEN  = 16;
  localparam int MAX_ROWS = 64;
  localparam int VAL_W    = 5;
  localparam int LEN_W    = 5;
  localparam int TGT_W    = 7;
  localparam int SLOT_W   = 4;
  localparam int ROW_W    = 6;
  localparam int ROW_BITS = MAX_LEN * VAL_W;

  typedef enum logic [2:0] {
    ST_REJECT = 3'd0,
    ST_TAKEN  = 3'd1,
    ST_STORED = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_ROW_TARGET = 1'b1
  } cfg_idx_e;

  // Control word broadcast to every cell of the row.
  typedef struct packed {
    logic             take;
    logic             clear;
    logic [VAL_W-1:0] cand;
  } cell_ctrl_t;

endpackage

[hdl/upc_cell.sv]
// One cell of the row: one line buffer entry, one used-map bit and the fill token.
// Depends on upc_pkg.
module upc_cell import upc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             first_i,
  input  logic [VAL_W-1:0] code_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             tok_i,
  output logic             tok_o,
  output logic             used_o,
  output logic [VAL_W-1:0] entry_o,
  input  logic [VAL_W-1:0] mem_entry_i,
  input  logic             en_i,
  output logic             eq_o
);

  logic             tok_q, tok_d;
  logic             used_q, used_d;
  logic [VAL_W-1:0] entry_q, entry_d;

  // The token marks the position to fill next; it moves one cell on each take.
  always_comb begin
    tok_d   = tok_q;
    used_d  = used_q;
    entry_d = entry_q;
    if (ctrl_i.take && tok_q) begin
      entry_d = ctrl_i.cand;
    end
    if (ctrl_i.take) begin
      tok_d = tok_i;
      if (ctrl_i.cand == code_i) begin
        used_d = 1'b1;
      end
    end
    if (ctrl_i.clear) begin
      tok_d  = first_i;
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= first_i;
      used_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign tok_o   = tok_q;
  assign used_o  = used_q;
  assign entry_o = entry_q;
  // Positions past the row length do not take part in the compare.
  assign eq_o    = !en_i || (entry_q == mem_entry_i);

endmodule

[hdl/unique_permutation_collector.sv]
// Top level of the unique permutation collector: control, row table and cell row.
// Depends on upc_pkg and upc_cell.
//
//   channel   | handshake                 | words
//   ----------+---------------------------+------------------------------
//   input     | start, busy               | candidate_i
//   result    | out_strobe_o              | status_o, slot_o, row_index_o
//   config    | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A word that does not finish a row gives its result in the cycle after start,
// and the next word may follow at once. A word that finishes a row starts a
// scan of the row table, one stored row per cycle through the table read port,
// and busy stays high until the scan finds a match or the row is stored.
// Reset clears the control state; the row table needs no clearing since only
// stored rows are read. Results cannot be stalled.
module unique_permutation_collector import upc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [VAL_W-1:0]  candidate_i,
  output logic              out_strobe_o,
  output logic [2:0]        status_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [ROW_W-1:0]  row_index_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [TGT_W-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_cfg_q, len_cfg_d;
  logic [TGT_W-1:0]  tgt_cfg_q, tgt_cfg_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [TGT_W-1:0]  count_q, count_d;
  logic [TGT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ROW_BITS-1:0] rd_data_q;
  logic [ROW_BITS-1:0] wr_data;
  logic              wr_en, rd_en;
  logic [ROW_BITS-1:0] row_mem [MAX_ROWS];

  logic              ostb_q, ostb_d;
  logic [2:0]        ostat_q, ostat_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [ROW_W-1:0]  orow_q, orow_d;

  logic [LEN_W-1:0]  len;
  logic [TGT_W-1:0]  tgt;
  logic              full, cand_ok, hit, take, last, cfg_wr, row_eq;
  logic [MAX_LEN-1:0] used_vec, tok_vec, eq_vec, len_mask;
  logic [VAL_W-1:0]  entry_vec [MAX_LEN];
  logic [VAL_W-1:0]  cand_m1;
  cell_ctrl_t        ctrl;

  // Clamp the configuration to its legal ranges.
  always_comb begin
    if (len_cfg_q == '0) begin
      len = LEN_W'(1);
    end else if (len_cfg_q > LEN_W'(MAX_LEN)) begin
      len = LEN_W'(MAX_LEN);
    end else begin
      len = len_cfg_q;
    end
    if (tgt_cfg_q == '0) begin
      tgt = TGT_W'(1);
    end else if (tgt_cfg_q > TGT_W'(MAX_ROWS)) begin
      tgt = TGT_W'(MAX_ROWS);
    end else begin
      tgt = tgt_cfg_q;
    end
  end

  assign busy        = (state_q == S_SCAN);
  assign cfg_ready_o = !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Candidate check against the range and the used map.
  assign full    = (count_q >= tgt);
  assign cand_ok = (candidate_i != '0) && (candidate_i <= len);
  assign cand_m1 = candidate_i - VAL_W'(1);
  assign hit     = used_vec[cand_m1[SLOT_W-1:0]];
  assign take    = start && !busy && !full && cand_ok && !hit;
  assign last    = ((fill_q + LEN_W'(1)) == len);

  assign ctrl.take  = take;
  assign ctrl.clear = (take && last) || (cfg_wr && cfg_index_i == CFG_ROW_LENGTH);
  assign ctrl.cand  = candidate_i;

  // The row of cells.
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_link
      assign tok_in = tok_vec[i-1];
    end
    assign len_mask[i] = (LEN_W'(i) < len);
    assign wr_data[i*VAL_W +: VAL_W] = len_mask[i] ? entry_vec[i] : '0;

    upc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .first_i     (i == 0),
      .code_i      (VAL_W'(i + 1)),
      .ctrl_i      (ctrl),
      .tok_i       (tok_in),
      .tok_o       (tok_vec[i]),
      .used_o      (used_vec[i]),
      .entry_o     (entry_vec[i]),
      .mem_entry_i (rd_data_q[i*VAL_W +: VAL_W]),
      .en_i        (len_mask[i]),
      .eq_o        (eq_vec[i])
    );
  end

  assign row_eq = &eq_vec;

  // Control: intake of words, then the scan over the stored rows.
  always_comb begin
    state_d   = state_q;
    len_cfg_d = len_cfg_q;
    tgt_cfg_d = tgt_cfg_q;
    fill_d    = fill_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    ostb_d    = 1'b0;
    ostat_d   = ostat_q;
    oslot_d   = oslot_q;
    orow_d    = orow_q;

    if (cfg_wr) begin
      if (cfg_index_i == CFG_ROW_LENGTH) begin
        len_cfg_d = cfg_data_i[LEN_W-1:0];
        fill_d    = '0;
      end else begin
        tgt_cfg_d = cfg_data_i;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          oslot_d = fill_q[SLOT_W-1:0];
          orow_d  = count_q[ROW_W-1:0];
          if (full) begin
            ostb_d  = 1'b1;
            ostat_d = ST_FULL;
            oslot_d = '0;
            orow_d  = '0;
          end else if (!take) begin
            ostb_d  = 1'b1;
            ostat_d = ST_REJECT;
          end else if (!last) begin
            ostb_d  = 1'b1;
            ostat_d = ST_TAKEN;
            fill_d  = fill_q + LEN_W'(1);
          end else begin
            fill_d   = '0;
            rd_idx_d = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        oslot_d = SLOT_W'(len - LEN_W'(1));
        if (rd_vld_q && row_eq) begin
          ostb_d  = 1'b1;
          ostat_d = ST_DUP;
          orow_d  = count_q[ROW_W-1:0];
          state_d = S_IDLE;
        end else if (!rd_vld_q && rd_idx_q >= count_q) begin
          wr_en   = 1'b1;
          ostb_d  = 1'b1;
          ostat_d = ST_STORED;
          orow_d  = count_q[ROW_W-1:0];
          count_d = count_q + TGT_W'(1);
          state_d = S_IDLE;
        end else if (rd_idx_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + TGT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_cfg_q <= LEN_W'(MAX_LEN);
      tgt_cfg_q <= TGT_W'(MAX_ROWS);
      fill_q    <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      ostb_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_cfg_q <= len_cfg_d;
      tgt_cfg_q <= tgt_cfg_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      ostb_q    <= ostb_d;
    end
  end

  // Result words and the row table.
  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    oslot_q <= oslot_d;
    orow_q  <= orow_d;
    if (rd_en) begin
      rd_data_q <= row_mem[rd_idx_q[ROW_W-1:0]];
    end
    if (wr_en) begin
      row_mem[count_q[ROW_W-1:0]] <= wr_data;
    end
  end

  assign out_strobe_o = ostb_q;
  assign status_o     = ostat_q;
  assign slot_o       = oslot_q;
  assign row_index_o  = orow_q;

  // The fill token sits in exactly one cell.
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tok_vec)) else $error("fill token lost or doubled");

  // The fill position stays inside the row.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < len) else $error("fill position past row length");

  // The table never holds more rows than it has room for.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TGT_W'(MAX_ROWS)) else $error("row count overflow");

  // A row is stored only in the scan and with no table read still in flight.
  a_store_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (busy && !rd_vld_q)) else $error("row stored mid-scan");

endmodule
